// ===== rtl/core/sct_pkg.sv =====
// shared types and constants of the shell command tokenizer
package sct_pkg;

   localparam int LEN_MAX_W = 6;
   localparam int INDEX_W   = 6;
   localparam int COUNT_W   = 7;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_DASH   = 8'h2D;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_BTICK  = 8'h60;

   localparam logic [1:0] TOK_COMMAND = 2'd0;
   localparam logic [1:0] TOK_SHORT   = 2'd1;
   localparam logic [1:0] TOK_LONG    = 2'd2;
   localparam logic [1:0] TOK_WORD    = 2'd3;

   // one queued job: an optional token run, then an optional end report
   typedef struct packed {
      logic                 has_token;
      logic                 bank;
      logic [LEN_MAX_W-1:0] len;
      logic [1:0]           ttype;
      logic [INDEX_W-1:0]   index;
      logic                 has_end;
      logic                 status;
      logic [COUNT_W-1:0]   count;
   } entry_type;

   typedef struct packed {
      logic valid;
      logic bank;
   } release_type;

   typedef struct packed {
      logic [7:0]         char_out;
      logic               char_valid;
      logic [1:0]         token_type;
      logic [INDEX_W-1:0] token_index;
      logic               token_last;
      logic               end_of_command;
      logic               status;
      logic [COUNT_W-1:0] token_count;
      logic               last;
   } result_type;

endpackage

// ===== rtl/core/sct_ram.sv =====
// generic single-write, single-read RAM with registered read data
module sct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

endmodule

// ===== rtl/core/sct_queue.sv =====
// two-entry job queue between the lexer and the emitter
module sct_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  sct_pkg::entry_type push_entry,
   input  logic               pop,
   output sct_pkg::entry_type head,
   output logic               full,
   output logic               empty
);
   import sct_pkg::*;

   entry_type  slot_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      cnt_in  = cnt_ff;
      if (push) begin
         wptr_in = ~wptr_ff;
      end
      if (pop) begin
         rptr_in = ~rptr_ff;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= push_entry;
      end
   end

   assign head  = slot_ff[rptr_ff];
   assign full  = (cnt_ff == 2'd2);
   assign empty = (cnt_ff == 2'd0);

endmodule

// ===== rtl/core/sct_front.sv =====
// lexer: takes command bytes, fills the token buffer, queues token and end jobs
module sct_front #(
   parameter int TOKEN_BYTES = 64,
   parameter int MAX_TOKENS  = 64,
   parameter int LEN_W       = 6
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,
   input  logic                 q_full,
   output logic                 q_push,
   output sct_pkg::entry_type   q_entry,
   input  sct_pkg::release_type rel,
   output logic                 buf_we,
   output logic [LEN_W:0]       buf_waddr,
   output logic [7:0]           buf_wdata
);
   import sct_pkg::*;

   localparam logic [2:0] M_NORMAL = 3'd0;
   localparam logic [2:0] M_SQUOTE = 3'd1;
   localparam logic [2:0] M_DQUOTE = 3'd2;
   localparam logic [2:0] M_ESCAPE = 3'd3;
   localparam logic [2:0] M_DQESC  = 3'd4;

   localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(TOKEN_BYTES - 1);

   logic [2:0]         mode_ff, mode_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic               inside_ff, inside_in;
   logic               sep_ff, sep_in;
   logic [COUNT_W-1:0] done_ff, done_in;
   logic               ovf_ff, ovf_in;
   logic               wbank_ff, wbank_in;
   logic [1:0]         busy_ff, busy_in;
   logic               d0_ff, d0_in;
   logic               d1_ff, d1_in;
   logic               pend_ff, pend_in;
   logic [7:0]         pend_ch_ff, pend_ch_in;

   logic       accept;
   logic [7:0] c;
   logic       is_blank;
   logic       app_en;
   logic [7:0] app_ch;
   logic       app_do;
   logic       finish;
   logic       end_cmd;
   logic       emit;
   logic       ovf_set;
   logic [1:0] emit_type;

   assign c        = req_tdata;
   assign accept   = req_tvalid && req_tready;
   assign is_blank = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   assign req_tready = !reset && !pend_ff && !busy_ff[wbank_ff] && !q_full;

   always_comb begin
      mode_in    = mode_ff;
      len_in     = len_ff;
      inside_in  = inside_ff;
      sep_in     = sep_ff;
      done_in    = done_ff;
      ovf_in     = ovf_ff;
      wbank_in   = wbank_ff;
      busy_in    = busy_ff;
      d0_in      = d0_ff;
      d1_in      = d1_ff;
      pend_in    = 1'b0;
      pend_ch_in = pend_ch_ff;
      app_en     = 1'b0;
      app_ch     = c;
      app_do     = 1'b0;
      finish     = 1'b0;
      end_cmd    = 1'b0;
      emit       = 1'b0;
      ovf_set    = 1'b0;
      emit_type  = TOK_WORD;

      if (pend_ff) begin
         app_en = 1'b1;
         app_ch = pend_ch_ff;
      end else if (accept) begin
         if (ovf_ff) begin
            end_cmd = (c == CH_NUL);
         end else begin
            unique case (mode_ff)
               M_NORMAL: begin
                  if (c == CH_NUL || is_blank) begin
                     finish  = inside_ff;
                     end_cmd = (c == CH_NUL);
                  end else begin
                     inside_in = 1'b1;
                     if (c == CH_SQUOTE) begin
                        mode_in = M_SQUOTE;
                     end else if (c == CH_DQUOTE) begin
                        mode_in = M_DQUOTE;
                     end else if (c == CH_BSLASH) begin
                        mode_in = M_ESCAPE;
                     end else begin
                        app_en = 1'b1;
                     end
                  end
               end
               M_SQUOTE: begin
                  if (c == CH_NUL) begin
                     end_cmd = 1'b1;
                  end else if (c == CH_SQUOTE) begin
                     mode_in = M_NORMAL;
                  end else begin
                     app_en = 1'b1;
                  end
               end
               M_DQUOTE: begin
                  if (c == CH_NUL) begin
                     end_cmd = 1'b1;
                  end else if (c == CH_DQUOTE) begin
                     mode_in = M_NORMAL;
                  end else if (c == CH_BSLASH) begin
                     mode_in = M_DQESC;
                  end else begin
                     app_en = 1'b1;
                  end
               end
               M_ESCAPE: begin
                  if (c == CH_NUL) begin
                     end_cmd = 1'b1;
                  end else begin
                     app_en  = 1'b1;
                     mode_in = M_NORMAL;
                  end
               end
               M_DQESC: begin
                  if (c == CH_NUL) begin
                     end_cmd = 1'b1;
                  end else begin
                     app_en  = 1'b1;
                     mode_in = M_DQUOTE;
                     // backslash is kept: store it now, the byte next cycle
                     if (c != CH_DQUOTE && c != CH_BSLASH && c != CH_DOLLAR &&
                         c != CH_BTICK) begin
                        app_ch     = CH_BSLASH;
                        pend_in    = 1'b1;
                        pend_ch_in = c;
                     end
                  end
               end
               default: begin
                  mode_in = M_NORMAL;
               end
            endcase
         end
      end

      // append with overflow drop
      if (app_en && (len_ff < LEN_CAP)) begin
         app_do = 1'b1;
         len_in = len_ff + LEN_W'(1);
         if (len_ff == '0) begin
            d0_in = (app_ch == CH_DASH);
         end
         if (len_ff == LEN_W'(1)) begin
            d1_in = (app_ch == CH_DASH);
         end
      end

      if (finish) begin
         inside_in = 1'b0;
         len_in    = '0;
         if (done_ff >= COUNT_W'(MAX_TOKENS)) begin
            ovf_set = 1'b1;
            ovf_in  = 1'b1;
         end else if (done_ff == '0) begin
            emit      = 1'b1;
            emit_type = TOK_COMMAND;
         end else if (!sep_ff && (7'(len_ff) == 7'd2) && d0_ff && d1_ff) begin
            // first bare double dash is dropped
            sep_in = 1'b1;
         end else if (!sep_ff && (7'(len_ff) >= 7'd2) && d0_ff) begin
            emit      = 1'b1;
            emit_type = d1_ff ? TOK_LONG : TOK_SHORT;
         end else begin
            emit      = 1'b1;
            emit_type = TOK_WORD;
         end
         if (emit) begin
            done_in  = done_ff + COUNT_W'(1);
            wbank_in = ~wbank_ff;
         end
      end

      if (end_cmd) begin
         mode_in   = M_NORMAL;
         len_in    = '0;
         inside_in = 1'b0;
         sep_in    = 1'b0;
         done_in   = '0;
         ovf_in    = 1'b0;
      end

      if (rel.valid) begin
         busy_in[rel.bank] = 1'b0;
      end
      if (emit) begin
         busy_in[wbank_ff] = 1'b1;
      end
   end

   always_comb begin
      q_push            = emit || end_cmd;
      q_entry.has_token = emit;
      q_entry.bank      = wbank_ff;
      q_entry.len       = LEN_MAX_W'(len_ff);
      q_entry.ttype     = emit_type;
      q_entry.index     = done_ff[INDEX_W-1:0];
      q_entry.has_end   = end_cmd;
      q_entry.status    = ovf_ff || ovf_set;
      q_entry.count     = emit ? (done_ff + COUNT_W'(1)) : done_ff;
   end

   assign buf_we    = app_do;
   assign buf_waddr = {wbank_ff, len_ff};
   assign buf_wdata = app_ch;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= M_NORMAL;
         len_ff    <= '0;
         inside_ff <= 1'b0;
         sep_ff    <= 1'b0;
         done_ff   <= '0;
         ovf_ff    <= 1'b0;
         wbank_ff  <= 1'b0;
         busy_ff   <= 2'b00;
         pend_ff   <= 1'b0;
      end else begin
         mode_ff   <= mode_in;
         len_ff    <= len_in;
         inside_ff <= inside_in;
         sep_ff    <= sep_in;
         done_ff   <= done_in;
         ovf_ff    <= ovf_in;
         wbank_ff  <= wbank_in;
         busy_ff   <= busy_in;
         pend_ff   <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      d0_ff      <= d0_in;
      d1_ff      <= d1_in;
      pend_ch_ff <= pend_ch_in;
   end

endmodule

// ===== rtl/core/sct_back.sv =====
// emitter: plays queued jobs out of the token buffer into the result register
module sct_back #(
   parameter int LEN_W = 6
) (
   input  logic                 clock,
   input  logic                 reset,
   input  sct_pkg::entry_type   q_head,
   input  logic                 q_empty,
   output logic                 q_pop,
   output logic [LEN_W:0]       buf_raddr,
   input  logic [7:0]           buf_rdata,
   output sct_pkg::release_type rel,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output sct_pkg::result_type  rsp_result
);
   import sct_pkg::*;

   localparam logic [2:0] B_IDLE  = 3'd0;
   localparam logic [2:0] B_PRIME = 3'd1;
   localparam logic [2:0] B_CHAR  = 3'd2;
   localparam logic [2:0] B_EMPTY = 3'd3;
   localparam logic [2:0] B_END   = 3'd4;

   logic [2:0]       state_ff, state_in;
   entry_type        ent_ff, ent_in;
   logic [LEN_W-1:0] idx_ff, idx_in;
   logic             valid_ff, valid_in;
   result_type       res_ff, res_in;

   logic             out_free;
   logic             char_load;
   logic             at_last;

   assign out_free  = !valid_ff || rsp_tready;
   assign at_last   = (idx_ff == LEN_W'(ent_ff.len - LEN_MAX_W'(1)));
   assign char_load = (state_ff == B_CHAR) && out_free;
   // read address runs one ahead when a character leaves
   assign buf_raddr = {ent_ff.bank, (char_load ? idx_ff + LEN_W'(1) : idx_ff)};

   always_comb begin
      state_in  = state_ff;
      ent_in    = ent_ff;
      idx_in    = idx_ff;
      valid_in  = valid_ff && !rsp_tready;
      res_in    = res_ff;
      q_pop     = 1'b0;
      rel.valid = 1'b0;
      rel.bank  = ent_ff.bank;

      unique case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               q_pop  = 1'b1;
               ent_in = q_head;
               idx_in = '0;
               if (!q_head.has_token) begin
                  state_in = B_END;
               end else if (q_head.len == '0) begin
                  state_in = B_EMPTY;
               end else begin
                  state_in = B_PRIME;
               end
            end
         end
         B_PRIME: begin
            state_in = B_CHAR;
         end
         B_CHAR: begin
            if (out_free) begin
               valid_in              = 1'b1;
               res_in                = '0;
               res_in.char_out       = buf_rdata;
               res_in.char_valid     = 1'b1;
               res_in.token_type     = ent_ff.ttype;
               res_in.token_index    = ent_ff.index;
               res_in.token_last     = at_last;
               res_in.last           = at_last && !ent_ff.has_end;
               idx_in                = idx_ff + LEN_W'(1);
               if (at_last) begin
                  rel.valid = 1'b1;
                  state_in  = ent_ff.has_end ? B_END : B_IDLE;
               end
            end
         end
         B_EMPTY: begin
            if (out_free) begin
               valid_in           = 1'b1;
               res_in             = '0;
               res_in.token_type  = ent_ff.ttype;
               res_in.token_index = ent_ff.index;
               res_in.token_last  = 1'b1;
               res_in.last        = !ent_ff.has_end;
               rel.valid          = 1'b1;
               state_in           = ent_ff.has_end ? B_END : B_IDLE;
            end
         end
         B_END: begin
            if (out_free) begin
               valid_in              = 1'b1;
               res_in                = '0;
               res_in.end_of_command = 1'b1;
               res_in.status         = ent_ff.status;
               res_in.token_count    = ent_ff.count;
               res_in.last           = 1'b1;
               state_in              = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
      idx_ff <= idx_in;
      res_ff <= res_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_result = res_ff;

endmodule

// ===== rtl/core/shell_command_tokenizer.sv =====
// shell command tokenizer: lexer front, job queue, two-bank token buffer, emitter back
// throughput: one byte per cycle into the lexer unless stalled; one beat per cycle within a run
// while the result is taken; each job is popped before it plays and, for a token, the buffer is
// read in a priming state before its first character
// stalls: a buffer bank still being emitted, a full queue, a kept backslash in quotes
// reset: synchronous, clears lexer mode, counters, queue, bank flags and the result valid flag
module shell_command_tokenizer #(
   parameter int TOKEN_BYTES = 64,
   parameter int MAX_TOKENS  = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] char_out, [13:8] token_index, [14] status,
                                    // [21:15] token_count, [22] last, [23] zero
   output logic [3:0]  rsp_tuser,   // [0] char_valid, [2:1] token_type, [3] end_of_command
   output logic        rsp_tlast    // token_last
);
   import sct_pkg::*;

   localparam int LEN_W = $clog2(TOKEN_BYTES);

   logic           q_full;
   logic           q_empty;
   logic           q_push;
   logic           q_pop;
   entry_type      q_entry;
   entry_type      q_head;
   release_type    rel;
   logic           buf_we;
   logic [LEN_W:0] buf_waddr;
   logic [LEN_W:0] buf_raddr;
   logic [7:0]     buf_wdata;
   logic [7:0]     buf_rdata;
   result_type     res;

   sct_front #(
      .TOKEN_BYTES (TOKEN_BYTES),
      .MAX_TOKENS  (MAX_TOKENS),
      .LEN_W       (LEN_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (q_entry),
      .rel        (rel),
      .buf_we     (buf_we),
      .buf_waddr  (buf_waddr),
      .buf_wdata  (buf_wdata)
   );

   sct_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .head       (q_head),
      .full       (q_full),
      .empty      (q_empty)
   );

   sct_ram #(
      .WIDTH (8),
      .DEPTH (2 ** (LEN_W + 1))
   ) u_buf (
      .clock    (clock),
      .we       (buf_we),
      .waddr    (buf_waddr),
      .wdata    (buf_wdata),
      .raddr    (buf_raddr),
      .rdata_ff (buf_rdata)
   );

   sct_back #(
      .LEN_W (LEN_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_head     (q_head),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .buf_raddr  (buf_raddr),
      .buf_rdata  (buf_rdata),
      .rel        (rel),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_result (res)
   );

   assign rsp_tdata = {1'b0, res.last, res.token_count, res.status, res.token_index,
                       res.char_out};
   assign rsp_tuser = {res.end_of_command, res.token_type, res.char_valid};
   assign rsp_tlast = res.token_last;

endmodule

// ===== rtl/core/sct_checker.sv =====
// port-level checker for the shell command tokenizer, bound to the top level
module sct_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [3:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result beat changed while stalled");

   // end report closes the byte's results and carries no character
   a_end_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[3] |-> rsp_tdata[22] && !rsp_tuser[0] &&
      rsp_tuser[2:1] == 2'd0 && !rsp_tlast && rsp_tdata[7:0] == 8'd0)
      else $error("malformed end report");

   // token beats carry no status or count
   a_token_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[3] |-> rsp_tdata[21:14] == 8'd0)
      else $error("token beat carries end fields");

   // empty token is a single beat run
   a_empty_token: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] && !rsp_tuser[3] |-> rsp_tlast &&
      rsp_tdata[7:0] == 8'd0)
      else $error("empty token beat not closing its run");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_reset_no_accept: assert property (@(posedge clock)
      reset |-> !req_tready)
      else $error("input ready during reset");

endmodule

bind shell_command_tokenizer sct_checker u_sct_checker (.*);

// ===== sim/tokenizer_tb_pkg.sv =====
// scoreboard class that predicts and checks the tokenizer result beats
package tokenizer_tb_pkg;

   timeunit 1ns;
   timeprecision 1ps;

   import sct_pkg::*;

   localparam int TOKEN_BYTES = 64;
   localparam int MAX_TOKENS  = 64;

   typedef enum int {
      LX_PLAIN,
      LX_SINGLE,
      LX_DOUBLE,
      LX_ESCAPE,
      LX_DQ_ESCAPE
   } lex_state_type;

   function automatic bit is_blank(logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
   endfunction

   class tokenizer_scoreboard;
      lex_state_type mode;
      logic [7:0]    word_buf [TOKEN_BYTES-1];
      int unsigned   word_len;
      int unsigned   emitted;
      bit            in_word;
      bit            dashdash_seen;
      bit            too_many;
      result_type    result_beats [$];
      int            errors;

      function new();
         errors = 0;
         clear_line();
      endfunction

      function void clear_line();
         mode          = LX_PLAIN;
         word_len      = 0;
         emitted       = 0;
         in_word       = 1'b0;
         dashdash_seen = 1'b0;
         too_many      = 1'b0;
      endfunction

      function void keep_char(logic [7:0] c);
         if (word_len < TOKEN_BYTES - 1) begin
            word_buf[word_len] = c;
            word_len++;
         end
      endfunction

      function void push_beat(logic [7:0] c, bit cv, logic [1:0] kind, int unsigned idx,
                              bit tl, bit eoc, bit st, int unsigned cnt);
         result_type r;
         r.char_out       = c;
         r.char_valid     = cv;
         r.token_type     = kind;
         r.token_index    = idx[INDEX_W-1:0];
         r.token_last     = tl;
         r.end_of_command = eoc;
         r.status         = st;
         r.token_count    = cnt[COUNT_W-1:0];
         r.last           = 1'b0;
         result_beats.push_back(r);
      endfunction

      function void close_token();
         logic [1:0]  kind;
         int unsigned n;
         n        = word_len;
         in_word  = 1'b0;
         word_len = 0;
         if (emitted >= MAX_TOKENS) begin
            too_many = 1'b1;
            return;
         end
         if (emitted == 0) begin
            kind = TOK_COMMAND;
         end else if (!dashdash_seen && n == 2 && word_buf[0] == CH_DASH &&
                      word_buf[1] == CH_DASH) begin
            // the first bare double dash is swallowed
            dashdash_seen = 1'b1;
            return;
         end else if (!dashdash_seen && n >= 2 && word_buf[0] == CH_DASH) begin
            kind = (word_buf[1] == CH_DASH) ? TOK_LONG : TOK_SHORT;
         end else begin
            kind = TOK_WORD;
         end
         if (n == 0) begin
            push_beat(8'h00, 1'b0, kind, emitted, 1'b1, 1'b0, 1'b0, 0);
         end else begin
            for (int i = 0; i < n; i++)
               push_beat(word_buf[i], 1'b1, kind, emitted, i == n - 1, 1'b0, 1'b0, 0);
         end
         emitted++;
      endfunction

      function void end_line();
         push_beat(8'h00, 1'b0, TOK_COMMAND, 0, 1'b0, 1'b1, too_many, emitted);
         clear_line();
      endfunction

      // one accepted input beat
      function void lex_byte(logic [7:0] c);
         int         beats_at_start;
         result_type r;
         beats_at_start = result_beats.size();
         if (too_many) begin
            if (c == CH_NUL)
               end_line();
         end else begin
            case (mode)
               LX_PLAIN: begin
                  if (c == CH_NUL || is_blank(c)) begin
                     if (in_word)
                        close_token();
                     if (c == CH_NUL)
                        end_line();
                  end else begin
                     in_word = 1'b1;
                     if (c == CH_SQUOTE)
                        mode = LX_SINGLE;
                     else if (c == CH_DQUOTE)
                        mode = LX_DOUBLE;
                     else if (c == CH_BSLASH)
                        mode = LX_ESCAPE;
                     else
                        keep_char(c);
                  end
               end
               LX_SINGLE: begin
                  if (c == CH_NUL)
                     end_line();
                  else if (c == CH_SQUOTE)
                     mode = LX_PLAIN;
                  else
                     keep_char(c);
               end
               LX_DOUBLE: begin
                  if (c == CH_NUL)
                     end_line();
                  else if (c == CH_DQUOTE)
                     mode = LX_PLAIN;
                  else if (c == CH_BSLASH)
                     mode = LX_DQ_ESCAPE;
                  else
                     keep_char(c);
               end
               LX_ESCAPE: begin
                  if (c == CH_NUL) begin
                     end_line();
                  end else begin
                     keep_char(c);
                     mode = LX_PLAIN;
                  end
               end
               default: begin
                  if (c == CH_NUL) begin
                     end_line();
                  end else begin
                     // inside double quotes the backslash stays unless it escapes something
                     if (!(c inside {CH_DQUOTE, CH_BSLASH, CH_DOLLAR, CH_BTICK}))
                        keep_char(CH_BSLASH);
                     keep_char(c);
                     mode = LX_DOUBLE;
                  end
               end
            endcase
         end
         if (result_beats.size() > beats_at_start) begin
            r = result_beats.pop_back();
            r.last = 1'b1;
            result_beats.push_back(r);
         end
      endfunction

      function void compare(string name, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (result_beats.size() == 0) begin
            $display("%0t: unexpected result beat, expected none got %h", $time, got);
            errors++;
            return;
         end
         want = result_beats.pop_front();
         compare("char_out", want.char_out, got.char_out);
         compare("char_valid", 8'(want.char_valid), 8'(got.char_valid));
         compare("token_type", 8'(want.token_type), 8'(got.token_type));
         compare("token_index", 8'(want.token_index), 8'(got.token_index));
         compare("token_last", 8'(want.token_last), 8'(got.token_last));
         compare("end_of_command", 8'(want.end_of_command), 8'(got.end_of_command));
         compare("status", 8'(want.status), 8'(got.status));
         compare("token_count", 8'(want.token_count), 8'(got.token_count));
         compare("last", 8'(want.last), 8'(got.last));
      endfunction

      function int pending();
         return result_beats.size();
      endfunction

      function void finish_check();
         if (result_beats.size() != 0) begin
            $display("%0t: missing result beats, expected %0d more got 0", $time,
                     result_beats.size());
            errors++;
         end
      endfunction
   endclass

endpackage

// ===== sim/testbench.sv =====
// top of the tokenizer testbench: clock, reset, byte driver, result monitor
module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   import sct_pkg::*;
   import tokenizer_tb_pkg::*;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [3:0]  rsp_tuser;
   logic        rsp_tlast;

   int idle_pct  = 0;
   int stall_pct = 0;
   int sent;

   logic [7:0] line_bytes [$];
   result_type rsp_beat;

   tokenizer_scoreboard tracker = new();

   shell_command_tokenizer #(
      .TOKEN_BYTES(TOKEN_BYTES),
      .MAX_TOKENS (MAX_TOKENS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // input beats go to the predictor before any result beat of the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            tracker.lex_byte(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            rsp_beat.char_out       = rsp_tdata[7:0];
            rsp_beat.token_index    = rsp_tdata[13:8];
            rsp_beat.status         = rsp_tdata[14];
            rsp_beat.token_count    = rsp_tdata[21:15];
            rsp_beat.last           = rsp_tdata[22];
            rsp_beat.char_valid     = rsp_tuser[0];
            rsp_beat.token_type     = rsp_tuser[2:1];
            rsp_beat.end_of_command = rsp_tuser[3];
            rsp_beat.token_last     = rsp_tlast;
            tracker.check_result(rsp_beat);
         end
      end
   end

   task automatic send_byte(logic [7:0] b);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_line();
      foreach (line_bytes[i])
         send_byte(line_bytes[i]);
      line_bytes.delete();
   endtask

   function automatic void add_byte(logic [7:0] b);
      line_bytes.push_back(b);
   endfunction

   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++)
         line_bytes.push_back(s[i]);
   endfunction

   function automatic logic [7:0] any_but(logic [7:0] c);
      logic [7:0] b;
      do b = 8'($urandom_range(1, 255)); while (b == c);
      return b;
   endfunction

   // a byte that stands for itself outside quotes
   function automatic logic [7:0] rand_plain();
      logic [7:0] b;
      do begin
         if ($urandom_range(3) == 0)
            b = 8'($urandom_range(1, 255));
         else
            b = 8'($urandom_range(8'h61, 8'h7A));
      end while (b == CH_SQUOTE || b == CH_DQUOTE || b == CH_BSLASH || is_blank(b));
      return b;
   endfunction

   function automatic logic [7:0] rand_blank();
      if ($urandom_range(1) == 0)
         return CH_SPACE;
      return CH_TAB + 8'($urandom_range(4));
   endfunction

   function automatic void add_plain(int lo, int hi);
      int n;
      n = $urandom_range(hi, lo);
      repeat (n) add_byte(rand_plain());
   endfunction

   function automatic void add_blanks(int lo);
      int n;
      n = $urandom_range(3, lo);
      repeat (n) add_byte(rand_blank());
   endfunction

   function automatic void add_dquoted();
      int n;
      add_byte(CH_DQUOTE);
      n = $urandom_range(5);
      repeat (n) begin
         case ($urandom_range(5))
            0: add_byte(rand_blank());
            1: add_byte(CH_SQUOTE);
            2: begin
               add_byte(CH_BSLASH);
               case ($urandom_range(3))
                  0: add_byte(CH_DQUOTE);
                  1: add_byte(CH_BSLASH);
                  2: add_byte(CH_DOLLAR);
                  default: add_byte(CH_BTICK);
               endcase
            end
            3: begin
               add_byte(CH_BSLASH);
               add_byte(rand_plain());
            end
            default: add_byte(rand_plain());
         endcase
      end
      add_byte(CH_DQUOTE);
   endfunction

   function automatic void add_token();
      int n;
      case ($urandom_range(11))
         0, 1: add_plain(1, 6);
         2: begin
            add_byte(CH_DASH);
            add_plain(1, 3);
         end
         3: begin
            add_byte(CH_DASH);
            add_byte(CH_DASH);
            add_plain(1, 5);
         end
         4: begin
            add_byte(CH_DASH);
            add_byte(CH_DASH);
         end
         5: begin
            add_byte(CH_SQUOTE);
            n = $urandom_range(5);
            repeat (n) add_byte(any_but(CH_SQUOTE));
            add_byte(CH_SQUOTE);
         end
         6: add_dquoted();
         7: begin
            if ($urandom_range(1) == 0) begin
               add_byte(CH_SQUOTE);
               add_byte(CH_SQUOTE);
            end else begin
               add_byte(CH_DQUOTE);
               add_byte(CH_DQUOTE);
            end
         end
         8: begin
            add_byte(CH_BSLASH);
            add_byte(8'($urandom_range(1, 255)));
            add_plain(0, 2);
         end
         9: begin
            add_plain(0, 2);
            add_dquoted();
            add_plain(0, 2);
         end
         10: add_byte(CH_DASH);
         default: begin
            // long flag whose second dash comes from a quote
            add_byte(CH_DASH);
            add_byte(CH_SQUOTE);
            add_byte(CH_DASH);
            add_plain(0, 3);
            add_byte(CH_SQUOTE);
         end
      endcase
   endfunction

   function automatic void add_random_line();
      int ntok;
      if ($urandom_range(3) == 0)
         add_blanks(1);
      ntok = $urandom_range(6, 1);
      for (int i = 0; i < ntok; i++) begin
         add_token();
         if (i != ntok - 1)
            add_blanks(1);
      end
      if ($urandom_range(3) == 0)
         add_blanks(1);
      // sometimes the line ends inside a quote or an escape
      if ($urandom_range(5) == 0) begin
         add_byte(CH_SPACE);
         case ($urandom_range(3))
            0: add_byte(CH_SQUOTE);
            1: add_byte(CH_DQUOTE);
            2: add_byte(CH_BSLASH);
            default: begin
               add_byte(CH_DQUOTE);
               add_plain(0, 2);
               add_byte(CH_BSLASH);
            end
         endcase
      end
      add_byte(CH_NUL);
   endfunction

   function automatic void add_noise_line();
      int n;
      n = $urandom_range(12, 1);
      repeat (n) add_byte(8'($urandom_range(1, 255)));
      add_byte(CH_NUL);
   endfunction

   function automatic void add_full_line(int ntok, bit noise);
      repeat (ntok) begin
         add_byte(rand_plain());
         add_byte(rand_blank());
      end
      if (noise) begin
         add_byte(CH_SQUOTE);
         repeat (10) add_byte(8'($urandom_range(1, 255)));
      end
      add_byte(CH_NUL);
   endfunction

   function automatic void add_long_line();
      add_byte(rand_plain());
      add_byte(CH_SPACE);
      add_byte(CH_DASH);
      add_plain(75, 75);
      add_byte(CH_NUL);
   endfunction

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // every token kind, the separator, escapes and early terminators
      add_text("c -a --b -- -x --");
      add_byte(CH_NUL);
      add_text("'' \"\\\"\\$\\");
      add_byte(CH_BTICK);
      add_text("\\q\" \\z -");
      add_byte(8'hFF);
      add_byte(CH_NUL);
      add_text("\"\\");
      add_byte(CH_NUL);
      add_text("\\");
      add_byte(CH_NUL);
      add_text("'a");
      add_byte(CH_NUL);
      add_byte(CH_NUL);
      send_line();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 64; stall_pct = 0;  add_long_line(); end
            2: begin idle_pct = 0;  stall_pct = 64; end
            default: begin
               idle_pct  = 30;
               stall_pct = 30;
               add_full_line(MAX_TOKENS + 2, 1'b1);
            end
         endcase
         send_line();
         sent = 0;
         while (sent < 8) begin
            if ($urandom_range(4) == 0)
               add_noise_line();
            else
               add_random_line();
            sent += line_bytes.size();
            send_line();
         end
      end
      req_tvalid <= 1'b0;

      while (tracker.pending() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      tracker.finish_check();
      if (tracker.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
